// File: hdl/assert_macros.svh
// Concurrent assertion helpers; they compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rstn, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: hdl/tppwm_pkg.sv
package tppwm_pkg;

    // Default widths
    localparam int DUTY_BITS_DEF = 16;
    localparam int VOLT_BITS_DEF = 16;

    // Configuration register map
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MOD_MODE = 2'd1;

    localparam int PERIOD_RESET = 4096;

    // Modulation schemes; the unused code behaves as sine PWM
    localparam logic [1:0] MODE_SVPWM  = 2'd0;
    localparam logic [1:0] MODE_MINMAX = 2'd1;
    localparam logic [1:0] MODE_SINE   = 2'd2;

    // Q2.14 constants: sqrt(3) and the 2/sqrt(3) injection gain
    localparam logic signed [15:0] SQRT3_Q14 = 16'sd28378;
    localparam logic signed [15:0] GAIN_Q14  = 16'sd18919;

    // Space vector sector numbers
    typedef logic [2:0] sector_t;
    localparam sector_t SECTOR_NONE = 3'd0;
    localparam sector_t SECTOR_1    = 3'd1;
    localparam sector_t SECTOR_2    = 3'd2;
    localparam sector_t SECTOR_3    = 3'd3;
    localparam sector_t SECTOR_4    = 3'd4;
    localparam sector_t SECTOR_5    = 3'd5;
    localparam sector_t SECTOR_6    = 3'd6;

endpackage

// File: hdl/tppwm_ref_if.sv
interface tppwm_ref_if #(
    parameter int VOLT_BITS = tppwm_pkg::VOLT_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [VOLT_BITS-1:0] v_alpha;
    logic signed [VOLT_BITS-1:0] v_beta;
    logic signed [VOLT_BITS-1:0] v_phase_a;
    logic signed [VOLT_BITS-1:0] v_phase_b;
    logic signed [VOLT_BITS-1:0] v_phase_c;

    modport source (
        output valid, v_alpha, v_beta, v_phase_a, v_phase_b, v_phase_c,
        input  ready
    );

    modport sink (
        input  valid, v_alpha, v_beta, v_phase_a, v_phase_b, v_phase_c,
        output ready
    );
endinterface

// File: hdl/tppwm_duty_if.sv
interface tppwm_duty_if #(
    parameter int DUTY_BITS = tppwm_pkg::DUTY_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [DUTY_BITS-1:0]   duty_a;
    logic [DUTY_BITS-1:0]   duty_b;
    logic [DUTY_BITS-1:0]   duty_c;
    tppwm_pkg::sector_t     sector_num;
    logic                   clipped;

    modport source (
        output valid, duty_a, duty_b, duty_c, sector_num, clipped,
        input  ready
    );

    modport sink (
        input  valid, duty_a, duty_b, duty_c, sector_num, clipped,
        output ready
    );
endinterface

// File: hdl/three_phase_pwm_modulator.sv
// An accepted transaction passes through stages 1 to 7 to its result on duty_cmd.
// Throughput: one transaction per cycle; seven register stages, each with its own
// valid bit, so bubbles fill while the output stalls and the input stalls only
// once all seven stages hold data.
// Reset (rst_n, asynchronous, active low) clears all valid bits and sets the
// period register to 4096 and mod_mode to 0; datapath registers are not reset.
`include "assert_macros.svh"

module three_phase_pwm_modulator #(
    parameter int DUTY_BITS = tppwm_pkg::DUTY_BITS_DEF,
    parameter int VOLT_BITS = tppwm_pkg::VOLT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tppwm_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [DUTY_BITS-1:0]               cfg_data,
    tppwm_ref_if.sink                          volt_ref,
    tppwm_duty_if.source                       duty_cmd
);
    import tppwm_pkg::*;

    localparam int FRAC = VOLT_BITS - 1;
    localparam int SW   = VOLT_BITS + 2;
    localparam int OPW  = VOLT_BITS + 18;
    localparam int PW   = OPW + DUTY_BITS + 1;
    localparam int W    = DUTY_BITS + 4;
    localparam int NSTG = 7;

    localparam logic [DUTY_BITS-1:0] PERIOD_RST = DUTY_BITS'(PERIOD_RESET);
    localparam logic signed [OPW-1:0] UNIT_F  = OPW'(1) <<< FRAC;
    localparam logic signed [OPW-1:0] HALF_FG = OPW'(1) <<< (FRAC + 15);

    // Truncate x / 2^k toward zero
    function automatic logic signed [PW-1:0] tz_shr(input logic signed [PW-1:0] x,
                                                   input int unsigned k);
        logic signed [PW-1:0] bias;
        logic signed [PW-1:0] sum;
        bias = x[PW-1] ? ((PW'(1) <<< k) - PW'(1)) : '0;
        sum  = x + bias;
        return sum >>> k;
    endfunction

    // Halve toward zero
    function automatic logic signed [W-1:0] half_tz(input logic signed [W-1:0] x);
        logic signed [W-1:0] bias;
        logic signed [W-1:0] sum;
        bias    = '0;
        bias[0] = x[W-1];
        sum     = x + bias;
        return sum >>> 1;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DUTY_BITS-1:0] period_reg;
    logic [1:0]           mode_reg;
    logic                 is_sv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
            mode_reg   <= MODE_SVPWM;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PERIOD:   period_reg <= cfg_data;
                REG_MOD_MODE: mode_reg   <= cfg_data[1:0];
                default:      ;
            endcase
        end
    end

    assign is_sv = (mode_reg == MODE_SVPWM);

    // ------------------------------------------------------------------
    // Pipeline control: valid bits and per-stage advance
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] adv;

    // Let a stage load when it is empty or its content moves on
    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || duty_cmd.ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        vld_next[0] = adv[0] ? volt_ref.valid : vld_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign volt_ref.ready = adv[0];

    // ------------------------------------------------------------------
    // Stage 1: min/max of the phases and common-mode-free references
    // ------------------------------------------------------------------
    logic signed [VOLT_BITS-1:0] p_c [3];
    logic signed [VOLT_BITS-1:0] mx01_c, mn01_c, mx_c, mn_c;
    logic signed [SW-1:0]        s1_s_next [3];

    logic signed [VOLT_BITS-1:0] s1_va_reg, s1_vb_reg;
    logic signed [VOLT_BITS-1:0] s1_p_reg [3];
    logic signed [SW-1:0]        s1_s_reg [3];

    always_comb
    begin
        p_c[0] = volt_ref.v_phase_a;
        p_c[1] = volt_ref.v_phase_b;
        p_c[2] = volt_ref.v_phase_c;
        mx01_c = (p_c[0] > p_c[1]) ? p_c[0] : p_c[1];
        mn01_c = (p_c[0] > p_c[1]) ? p_c[1] : p_c[0];
        mx_c   = (p_c[2] > mx01_c) ? p_c[2] : mx01_c;
        mn_c   = (p_c[2] < mn01_c) ? p_c[2] : mn01_c;
        for (int i = 0; i < 3; i++)
        begin
            s1_s_next[i] = (SW'(p_c[i]) <<< 1) - (SW'(mx_c) + SW'(mn_c));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_va_reg <= volt_ref.v_alpha;
            s1_vb_reg <= volt_ref.v_beta;
            s1_p_reg  <= p_c;
            s1_s_reg  <= s1_s_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sine offset or constant multiply (sqrt3 or injection gain)
    // ------------------------------------------------------------------
    logic signed [SW-1:0]  mcand_c [3];
    logic signed [15:0]    coef_c [3];
    logic signed [OPW-1:0] prod_c [3];
    logic signed [OPW-1:0] s2_op_next [3];
    logic signed [OPW-1:0] s2_op_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mcand_c[i] = (is_sv && i == 0) ? SW'(s1_va_reg) : s1_s_reg[i];
            coef_c[i]  = (is_sv && i == 0) ? SQRT3_Q14 : GAIN_Q14;
            prod_c[i]  = OPW'(mcand_c[i]) * OPW'(coef_c[i]);
            unique case (mode_reg)
                MODE_SVPWM:
                begin
                    if (i == 0)
                        s2_op_next[i] = prod_c[i];
                    else if (i == 1)
                        s2_op_next[i] = -OPW'(s1_vb_reg);
                    else
                        s2_op_next[i] = '0;
                end
                MODE_MINMAX: s2_op_next[i] = HALF_FG - prod_c[i];
                default:     s2_op_next[i] = UNIT_F + OPW'(s1_p_reg[i]);
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_op_reg <= s2_op_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: scale by the period (or half period for sine PWM)
    // ------------------------------------------------------------------
    logic signed [DUTY_BITS:0] m_c;
    logic signed [PW-1:0]      s3_pr_next [3];
    logic signed [PW-1:0]      s3_pr_reg [3];

    always_comb
    begin
        if (is_sv || mode_reg == MODE_MINMAX)
            m_c = (DUTY_BITS + 1)'(period_reg);
        else
            m_c = (DUTY_BITS + 1)'(period_reg[DUTY_BITS-1:1]);
        for (int i = 0; i < 3; i++)
        begin
            s3_pr_next[i] = PW'(s2_op_reg[i]) * PW'(m_c);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_pr_reg <= s3_pr_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: drop fraction bits, truncating toward zero
    // ------------------------------------------------------------------
    logic signed [W-1:0] s4_sc_next [3];
    logic signed [W-1:0] s4_sc_reg [3];

    always_comb
    begin
        unique case (mode_reg)
            MODE_SVPWM:
            begin
                s4_sc_next[0] = W'(tz_shr(s3_pr_reg[0], FRAC + 14));
                s4_sc_next[1] = W'(tz_shr(s3_pr_reg[1], FRAC));
                s4_sc_next[2] = '0;
            end
            MODE_MINMAX:
            begin
                for (int i = 0; i < 3; i++)
                    s4_sc_next[i] = W'(tz_shr(s3_pr_reg[i], FRAC + 16));
            end
            default:
            begin
                for (int i = 0; i < 3; i++)
                    s4_sc_next[i] = W'(tz_shr(s3_pr_reg[i], FRAC));
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s4_sc_reg <= s4_sc_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: X, Y, Z and sector decision
    // ------------------------------------------------------------------
    logic signed [W-1:0] ua_c, x_c, y_c, z_c;
    sector_t             sec_c;
    logic signed [W-1:0] s5_v_next [3];
    sector_t             s5_sec_next;
    logic signed [W-1:0] s5_v_reg [3];
    sector_t             s5_sec_reg;

    always_comb
    begin
        ua_c = s4_sc_reg[0];
        x_c  = s4_sc_reg[1];
        y_c  = half_tz(x_c - ua_c);
        z_c  = half_tz(x_c + ua_c);
        priority if (y_c < 0)
            sec_c = (z_c < 0) ? SECTOR_5 : ((x_c > 0) ? SECTOR_3 : SECTOR_4);
        else
            sec_c = (z_c < 0) ? ((x_c > 0) ? SECTOR_1 : SECTOR_6) : SECTOR_2;

        if (is_sv)
        begin
            s5_v_next[0] = x_c;
            s5_v_next[1] = y_c;
            s5_v_next[2] = z_c;
            s5_sec_next  = sec_c;
        end
        else
        begin
            s5_v_next   = s4_sc_reg;
            s5_sec_next = SECTOR_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s5_v_reg   <= s5_v_next;
            s5_sec_reg <= s5_sec_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: phase A compare value and per-phase offsets
    // ------------------------------------------------------------------
    logic signed [W-1:0] xv_c, yv_c, zv_c;
    logic signed [W-1:0] q2_c, h_c, sel_c, offb_c, offc_c, d0_c;
    logic signed [W-1:0] s6_d_next [3];
    logic signed [W-1:0] s6_off_next [3];
    logic signed [W-1:0] s6_d_reg [3];
    logic signed [W-1:0] s6_off_reg [3];
    sector_t             s6_sec_reg;

    always_comb
    begin
        xv_c = s5_v_reg[0];
        yv_c = s5_v_reg[1];
        zv_c = s5_v_reg[2];
        q2_c = W'({period_reg[DUTY_BITS-1:2], 1'b0});
        h_c  = W'(period_reg[DUTY_BITS-1:1]);

        unique case (s5_sec_reg)
            SECTOR_1, SECTOR_4:
            begin
                sel_c  = xv_c - zv_c;
                offb_c = zv_c;
                offc_c = zv_c - xv_c;
            end
            SECTOR_2, SECTOR_5:
            begin
                sel_c  = yv_c - zv_c;
                offb_c = zv_c;
                offc_c = -yv_c;
            end
            default:
            begin
                sel_c  = yv_c - xv_c;
                offb_c = xv_c - yv_c;
                offc_c = -yv_c;
            end
        endcase

        d0_c = half_tz(q2_c + h_c + sel_c);

        if (is_sv)
        begin
            for (int i = 0; i < 3; i++)
                s6_d_next[i] = d0_c;
            s6_off_next[0] = '0;
            s6_off_next[1] = offb_c;
            s6_off_next[2] = offc_c;
        end
        else
        begin
            s6_d_next = s5_v_reg;
            for (int i = 0; i < 3; i++)
                s6_off_next[i] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s6_d_reg   <= s6_d_next;
            s6_off_reg <= s6_off_next;
            s6_sec_reg <= s5_sec_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: final sums, saturation to 0..period, output register
    // ------------------------------------------------------------------
    logic signed [W-1:0]  t_c;
    logic signed [W-1:0]  raw_c [3];
    logic [DUTY_BITS-1:0] duty_next [3];
    logic                 clip_next;
    logic [DUTY_BITS-1:0] duty_reg [3];
    sector_t              sec_reg;
    logic                 clip_reg;

    always_comb
    begin
        t_c       = W'(period_reg);
        clip_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            raw_c[i] = s6_d_reg[i] + s6_off_reg[i];
            priority if (raw_c[i] < 0)
            begin
                duty_next[i] = '0;
                clip_next    = 1'b1;
            end
            else if (raw_c[i] > t_c)
            begin
                duty_next[i] = period_reg;
                clip_next    = 1'b1;
            end
            else
            begin
                duty_next[i] = raw_c[i][DUTY_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            duty_reg <= duty_next;
            sec_reg  <= s6_sec_reg;
            clip_reg <= clip_next;
        end
    end

    assign duty_cmd.valid      = vld_reg[NSTG-1];
    assign duty_cmd.duty_a     = duty_reg[0];
    assign duty_cmd.duty_b     = duty_reg[1];
    assign duty_cmd.duty_c     = duty_reg[2];
    assign duty_cmd.sector_num = sec_reg;
    assign duty_cmd.clipped    = clip_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLY(a_sector_range, clk, rst_n, vld_reg[NSTG-1], sec_reg <= SECTOR_6, "bad sector")
    `ASSERT_NEXT(a_accept_loads, clk, rst_n, volt_ref.valid && adv[0], vld_reg[0], "lost at entry")
    `ASSERT_IMPLY(a_ready_when_drained, clk, rst_n, !vld_reg[NSTG-1], adv[0], "input stalled")
    `ASSERT_NEXT(a_mid_stall_holds, clk, rst_n, vld_reg[3] && !adv[3], vld_reg[3], "stall drop")

endmodule
